/* rtl/core/sfsc_pkg.sv */
// Package for the six-frame stop codon scanner.
// Holds the transaction and state types, the character codes and the automaton table.
// Depends on nothing; used by sfsc_step and six_frame_stop_codon_scanner_core.
`default_nettype none

package sfsc_pkg;

	localparam int unsigned NUM_STATES = 10;
	localparam int unsigned NUM_FRAMES = 3;

	localparam logic [3:0] FWD_STOP_STATE = 4'd7;
	localparam logic [3:0] START_STATE    = 4'd0;

	localparam logic [7:0] CHAR_A_UP = 8'h41;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_G_UP = 8'h47;
	localparam logic [7:0] CHAR_T_UP = 8'h54;
	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_C_LO = 8'h63;
	localparam logic [7:0] CHAR_G_LO = 8'h67;
	localparam logic [7:0] CHAR_T_LO = 8'h74;

	localparam logic [1:0] NT_A = 2'd0;
	localparam logic [1:0] NT_C = 2'd1;
	localparam logic [1:0] NT_G = 2'd2;
	localparam logic [1:0] NT_T = 2'd3;

	localparam logic [1:0] PHASE_LAST = 2'd2;

	localparam logic [3:0] TRANS [NUM_STATES][4] = '{
		'{4'd0, 4'd2, 4'd0, 4'd1},
		'{4'd3, 4'd4, 4'd5, 4'd6},
		'{4'd0, 4'd2, 4'd0, 4'd6},
		'{4'd7, 4'd2, 4'd7, 4'd1},
		'{4'd8, 4'd2, 4'd0, 4'd6},
		'{4'd7, 4'd2, 4'd0, 4'd1},
		'{4'd9, 4'd4, 4'd5, 4'd6},
		'{4'd0, 4'd2, 4'd0, 4'd1},
		'{4'd0, 4'd2, 4'd0, 4'd1},
		'{4'd7, 4'd2, 4'd7, 4'd1}
	};

	typedef struct packed {
		logic [7:0] symbol;
		logic       first;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [2:0] forward_frames;
		logic [2:0] reverse_frames;
		logic       bad_char_seen;
	} result_t;

	typedef struct packed {
		logic [3:0] auto_state;
		logic [1:0] phase;
		logic [2:0] fwd;
		logic [2:0] rev;
		logic       bad;
	} scan_state_t;

	function automatic logic [3:0] next_auto_state(input logic [3:0] st, input logic [1:0] nt);
		logic [3:0] row;
		row = (st < 4'(NUM_STATES)) ? st : START_STATE;
		return TRANS[row][nt];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sfsc_step.sv */
// Next-state logic of the stop codon scanner for one character.
// Decodes the character, steps the automaton and phase, and sets the sticky flags.
// Depends on sfsc_pkg.
`default_nettype none

module sfsc_step
	import sfsc_pkg::*;
(
	input  var scan_state_t cur,
	input  var item_t       item,
	output var scan_state_t nxt
);

	scan_state_t base;
	logic        is_nt;
	logic [1:0]  nt;
	logic [1:0]  phase_n;
	logic [3:0]  auto_n;

	always_comb begin
		base = item.first ? '0 : cur;
		is_nt = 1'b1;
		nt = NT_A;
		case (item.symbol)
			CHAR_A_UP, CHAR_A_LO: nt = NT_A;
			CHAR_C_UP, CHAR_C_LO: nt = NT_C;
			CHAR_G_UP, CHAR_G_LO: nt = NT_G;
			CHAR_T_UP, CHAR_T_LO: nt = NT_T;
			default: is_nt = 1'b0;
		endcase
		phase_n = (base.phase >= PHASE_LAST) ? 2'd0 : base.phase + 2'd1;
		auto_n = is_nt ? next_auto_state(base.auto_state, nt) : START_STATE;
		nxt.auto_state = auto_n;
		nxt.phase = phase_n;
		nxt.bad = base.bad | ~is_nt;
		nxt.fwd = base.fwd;
		nxt.rev = base.rev;
		if (auto_n == FWD_STOP_STATE) begin
			nxt.fwd[phase_n] = 1'b1;
		end else if (auto_n > FWD_STOP_STATE) begin
			nxt.rev[phase_n] = 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/six_frame_stop_codon_scanner_core.sv */
// Top level of the six-frame stop codon scanner.
// Input register, one-character scan step and result register; uses sfsc_pkg and sfsc_step.
//
// Channel  Direction  Handshake                  Payload
// item     in         item_valid / item_stall    item_t   (symbol, first, last)
// result   out        result_valid / result_stall result_t (frames, bad flag)
//
// One character per cycle is accepted unless stalled; a last item loads the result register.
// Throughput is set by the single scan step between the input and result registers.
// Reset clears the valid bits and the scan state; the first character after reset is position 1.
// A stalled result holds items marked last in the input register; other items keep flowing.
`default_nettype none

module six_frame_stop_codon_scanner_core
	import sfsc_pkg::*;
(
	input  var logic    clk,
	input  var logic    arst_n,
	input  var logic    item_valid,
	output var logic    item_stall,
	input  var item_t   item,
	output var logic    result_valid,
	input  var logic    result_stall,
	output var result_t result
);

	logic        valid_s1;
	item_t       item_s1;
	scan_state_t st_q;
	scan_state_t st_next;
	logic        adv;
	logic        res_valid_q;
	result_t     res_q;

	sfsc_step u_step (
		.cur (st_q),
		.item(item_s1),
		.nxt (st_next)
	);

	assign adv = valid_s1 && (!item_s1.last || !res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && item_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.last) begin
			res_q.forward_frames <= st_next.fwd;
			res_q.reverse_frames <= st_next.rev;
			res_q.bad_char_seen <= st_next.bad;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.auto_state < 4'(NUM_STATES))
		else $error("automaton state out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase != 2'd3)
		else $error("position phase out of range");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last |=> res_valid_q)
		else $error("last transaction produced no result");

	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bad && !(adv && item_s1.first) |=> st_q.bad)
		else $error("bad-character flag dropped without first");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && item_s1.last && res_valid_q)
		else $error("input stalled without a blocked last transaction");

endmodule

`default_nettype wire

/* tb/sv/sfsc_scan_checker.sv */
`timescale 1ns / 1ps
// Checker for the six-frame stop codon scanner: watches both channels, predicts the flags.
// Compares each result transaction with the oldest prediction; uses types from sfsc_pkg.

module sfsc_scan_checker
	import sfsc_pkg::*;
(
	input  var logic    clk,
	input  var logic    arst_n,
	input  var logic    item_valid,
	input  var logic    item_stall,
	input  var item_t   item,
	input  var logic    result_valid,
	input  var logic    result_stall,
	input  var result_t result,
	output int          failures,
	output int          pending
);

	localparam logic [3:0] CODON_NEXT [10][4] = '{
		'{4'd0, 4'd2, 4'd0, 4'd1},
		'{4'd3, 4'd4, 4'd5, 4'd6},
		'{4'd0, 4'd2, 4'd0, 4'd6},
		'{4'd7, 4'd2, 4'd7, 4'd1},
		'{4'd8, 4'd2, 4'd0, 4'd6},
		'{4'd7, 4'd2, 4'd0, 4'd1},
		'{4'd9, 4'd4, 4'd5, 4'd6},
		'{4'd0, 4'd2, 4'd0, 4'd1},
		'{4'd0, 4'd2, 4'd0, 4'd1},
		'{4'd7, 4'd2, 4'd7, 4'd1}
	};

	logic [3:0] codon_st;
	logic [1:0] frame;
	logic [2:0] fwd_seen;
	logic [2:0] rev_seen;
	logic       bad_seen;
	result_t    flags_q[$];
	result_t    want;
	int         fail_count = 0;

	assign failures = fail_count;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_scan();
		codon_st = START_STATE;
		frame    = 2'd0;
		fwd_seen = 3'd0;
		rev_seen = 3'd0;
		bad_seen = 1'b0;
	endtask

	task automatic scan_symbol(input item_t it);
		logic [7:0] ch;
		logic [1:0] nt;
		bit         is_base;
		result_t    r;
		if (it.first) begin
			clear_scan();
		end
		frame = (frame >= PHASE_LAST) ? 2'd0 : frame + 2'd1;
		ch = it.symbol;
		if (ch >= "A" && ch <= "Z") begin
			ch = ch + ("a" - "A");
		end
		nt = NT_A;
		is_base = 1'b1;
		case (ch)
			CHAR_A_LO: nt = NT_A;
			CHAR_C_LO: nt = NT_C;
			CHAR_G_LO: nt = NT_G;
			CHAR_T_LO: nt = NT_T;
			default: is_base = 1'b0;
		endcase
		if (codon_st >= 4'd10) begin
			codon_st = START_STATE;
		end
		if (is_base) begin
			codon_st = CODON_NEXT[codon_st][nt];
		end else begin
			codon_st = START_STATE;
			bad_seen = 1'b1;
		end
		if (codon_st == FWD_STOP_STATE) begin
			fwd_seen[frame] = 1'b1;
		end else if (codon_st > FWD_STOP_STATE) begin
			rev_seen[frame] = 1'b1;
		end
		if (it.last) begin
			r.forward_frames = fwd_seen;
			r.reverse_frames = rev_seen;
			r.bad_char_seen  = bad_seen;
			flags_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			flags_q.delete();
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (flags_q.size() == 0) begin
					report_mismatch($sformatf("result %h with no transaction expected", result));
				end else begin
					want = flags_q.pop_front();
					if (result.forward_frames !== want.forward_frames) begin
						report_mismatch($sformatf("forward_frames got %b, want %b",
							result.forward_frames, want.forward_frames));
					end
					if (result.reverse_frames !== want.reverse_frames) begin
						report_mismatch($sformatf("reverse_frames got %b, want %b",
							result.reverse_frames, want.reverse_frames));
					end
					if (result.bad_char_seen !== want.bad_char_seen) begin
						report_mismatch($sformatf("bad_char_seen got %b, want %b",
							result.bad_char_seen, want.bad_char_seen));
					end
				end
			end
			if (item_valid && !item_stall) begin
				scan_symbol(item);
			end
			pending <= flags_q.size();
		end
	end

endmodule

/* tb/sv/tb_six_frame_stop_codon_scanner_core.sv */
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, character stimulus and receiver stalls.
// Instantiates six_frame_stop_codon_scanner_core and sfsc_scan_checker; uses sfsc_pkg.

module tb_six_frame_stop_codon_scanner_core;
	import sfsc_pkg::*;

	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	localparam logic [7:0] BASES [8] = '{
		CHAR_A_UP, CHAR_C_UP, CHAR_G_UP, CHAR_T_UP,
		CHAR_A_LO, CHAR_C_LO, CHAR_G_LO, CHAR_T_LO
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      failures;
	int      pending;

	logic    hold_req = 1'b0;
	bit      hold_done = 1'b0;
	int      stall_mode = 0;
	bit      gaps_on = 1'b0;
	int      burst_left = 0;
	int      sent_count = 0;
	int      quiet_cycles = 0;

	always #4 clk = ~clk;

	six_frame_stop_codon_scanner_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	sfsc_scan_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.failures     (failures),
		.pending      (pending)
	);

	task automatic send_item(input item_t it);
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sent_count++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_text(input string s, input bit mark_first);
		item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.symbol = s[i];
			it.first  = mark_first && (i == 0);
			it.last   = (i == s.len() - 1);
			send_item(it);
		end
	endtask

	task automatic send_random_seq(input int len, input bit mark_first);
		item_t it;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				it.symbol = 8'($urandom_range(0, 255));
			end else begin
				it.symbol = BASES[$urandom_range(0, 7)];
			end
			it.first = mark_first && (i == 0);
			it.last  = (i == len - 1);
			send_item(it);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stall_gen
		int cyc;
		cyc = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req && !hold_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 2) == 0);
					2: result_stall <= ((cyc % 7) < 3);
					default: result_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int    phase_no;
		int    target;
		item_t it;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The scan starts at position 1 without a first mark, then runs on past last.
		send_text("taa", 1'b0);
		send_text("TAG", 1'b0);
		send_text("tgA", 1'b1);
		send_text("ttaCTA", 1'b1);
		send_text("tcag", 1'b1);
		// One-character sequences with non-nucleotide extremes.
		it = '{symbol: 8'h00, first: 1'b1, last: 1'b1};
		send_item(it);
		it = '{symbol: 8'hFF, first: 1'b1, last: 1'b1};
		send_item(it);
		wait_drained();

		for (phase_no = 0; phase_no < 4; phase_no++) begin
			stall_mode <= phase_no;
			gaps_on = (phase_no % 2 == 1);
			target = sent_count + RANDOM_ITEMS / 4;
			if (phase_no == 2) begin
				// Short sequences against a blocked receiver fill the pipeline.
				hold_req <= 1'b1;
				repeat (30) send_random_seq($urandom_range(1, 3), 1'b1);
			end
			while (sent_count < target) begin
				if ($urandom_range(0, 9) < 8) begin
					send_random_seq(($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
						: $urandom_range(1, 9), $urandom_range(0, 6) != 0);
				end else begin
					it = item_t'(10'($urandom_range(0, 1023)));
					send_item(it);
				end
			end
			if (phase_no == 1) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* six_frame_stop_codon_scanner_core.f */
rtl/core/sfsc_pkg.sv
rtl/core/sfsc_step.sv
rtl/core/six_frame_stop_codon_scanner_core.sv
tb/sv/sfsc_scan_checker.sv
tb/sv/tb_six_frame_stop_codon_scanner_core.sv
